// File: sv/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg: shared types and constants of the DDA line rasterizer
// Coordinate and fixed-point widths, command codes and the queue item format.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_W         = 10;
  localparam int COORD_LIMIT     = 1 << COORD_W;
  localparam int FRAC_BITS       = 16;
  // magnitude of the slope is at most one, so one integer bit and a sign
  localparam int QUO_W           = FRAC_BITS + 1;
  localparam int SLOPE_W         = FRAC_BITS + 2;
  localparam int QCNT_W          = $clog2(QUO_W);
  localparam int OFFSET_W        = COORD_W + 1;
  localparam int PROD_W          = OFFSET_W + SLOPE_W;
  localparam int ACC_W           = PROD_W + 1;
  localparam int ROW_W           = 11;
  localparam int ROW_WIDTH_RESET = 640;
  localparam int INDEX_W         = 20;
  localparam int IDX_FULL_W      = COORD_W + ROW_W + 1;
  localparam int IN_DATA_W       = 40;
  localparam int OUT_DATA_W      = 40;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // a classified command as it waits between front and back
  typedef struct packed {
    cmd_t               cmd;
    logic               major_is_x;
    logic [COORD_W-1:0] major_origin;
    logic [COORD_W-1:0] major_lo;
    logic [COORD_W-1:0] major_hi;
    logic [COORD_W-1:0] minor_origin;
    logic [COORD_W-1:0] major_mag;
    logic [COORD_W-1:0] minor_mag;
    logic               slope_neg;
  } line_cmd_t;

endpackage

// File: sv/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front: command intake and classification
// Picks the major axis and slope sign of start commands and queues every
// command for the back end.
// ----------------------------------------------------------------------------
module dda_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // x_start [9:0], y_start [19:10], x_end [29:20], y_end [39:30]
  input  logic [dda_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command: start or step
  input  logic                               s_axis_tuser,
  output logic                               q_valid,
  output dda_pkg::line_cmd_t                 q_item,
  input  logic                               q_pop
);

  logic [dda_pkg::COORD_W-1:0]  x_start, y_start, x_end, y_end;
  logic signed [dda_pkg::COORD_W:0] dx, dy, dmaj, dmin;
  logic [dda_pkg::COORD_W:0]    adx_full, ady_full;
  logic [dda_pkg::COORD_W-1:0]  adx, ady;
  logic                         maj_x;
  dda_pkg::line_cmd_t           item;
  logic                         push;

  dda_pkg::line_cmd_t           queue [dda_pkg::QUEUE_DEPTH];
  logic [dda_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [dda_pkg::QCOUNT_W-1:0] count;

  assign x_start = s_axis_tdata[dda_pkg::COORD_W-1:0];
  assign y_start = s_axis_tdata[2*dda_pkg::COORD_W-1:dda_pkg::COORD_W];
  assign x_end   = s_axis_tdata[3*dda_pkg::COORD_W-1:2*dda_pkg::COORD_W];
  assign y_end   = s_axis_tdata[4*dda_pkg::COORD_W-1:3*dda_pkg::COORD_W];

  assign dx = signed'({1'b0, x_end}) - signed'({1'b0, x_start});
  assign dy = signed'({1'b0, y_end}) - signed'({1'b0, y_start});
  assign adx_full = dx[dda_pkg::COORD_W] ? unsigned'(-dx) : unsigned'(dx);
  assign ady_full = dy[dda_pkg::COORD_W] ? unsigned'(-dy) : unsigned'(dy);
  assign adx = adx_full[dda_pkg::COORD_W-1:0];
  assign ady = ady_full[dda_pkg::COORD_W-1:0];
  // ties go to y, which also covers equal endpoints
  assign maj_x = adx > ady;
  assign dmaj  = maj_x ? dx : dy;
  assign dmin  = maj_x ? dy : dx;

  always_comb begin
    item.cmd          = dda_pkg::cmd_t'(s_axis_tuser);
    item.major_is_x   = maj_x;
    item.major_origin = maj_x ? x_start : y_start;
    item.minor_origin = maj_x ? y_start : x_start;
    item.major_lo     = maj_x ? ((x_start < x_end) ? x_start : x_end)
                              : ((y_start < y_end) ? y_start : y_end);
    item.major_hi     = maj_x ? ((x_start < x_end) ? x_end : x_start)
                              : ((y_start < y_end) ? y_end : y_start);
    item.major_mag    = maj_x ? adx : ady;
    item.minor_mag    = maj_x ? ady : adx;
    item.slope_neg    = (dmaj[dda_pkg::COORD_W] != dmin[dda_pkg::COORD_W]) && (dmin != '0);
  end

  assign s_axis_tready = count != dda_pkg::QCOUNT_W'(dda_pkg::QUEUE_DEPTH);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = count != '0;
  assign q_item        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div: serial slope divider
// Restoring division of minor_mag * 2^FRAC_BITS by major_mag, one quotient
// bit per cycle; the dividend never exceeds the divisor.
// ----------------------------------------------------------------------------
module dda_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dda_pkg::COORD_W-1:0]   dividend,
  input  logic [dda_pkg::COORD_W-1:0]   divisor,
  output logic                          done,
  output logic [dda_pkg::QUO_W-1:0]     quotient
);

  logic                          busy;
  logic [dda_pkg::QCNT_W-1:0]    cnt;
  logic [dda_pkg::COORD_W:0]     rem;
  logic [dda_pkg::COORD_W-1:0]   div_d;
  logic                          ge;
  logic [dda_pkg::COORD_W:0]     diff, kept;

  assign ge   = rem >= {1'b0, div_d};
  assign diff = rem - {1'b0, div_d};
  assign kept = ge ? diff : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy     <= 1'b1;
        done     <= 1'b0;
        cnt      <= '0;
        rem      <= {1'b0, dividend};
        div_d    <= divisor;
        quotient <= '0;
      end else if (busy) begin
        // remainder stays below the divisor, so the shift fits
        rem      <= {kept[dda_pkg::COORD_W-1:0], 1'b0};
        quotient <= {quotient[dda_pkg::QUO_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        done     <= cnt == dda_pkg::QCNT_W'(dda_pkg::QUO_W - 1);
        if (cnt == dda_pkg::QCNT_W'(dda_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// File: sv/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back: line walker
// Holds the line state, runs the slope divider on starts of unequal endpoints
// and turns each step of an active line into one pixel: multiply, add, index.
// ----------------------------------------------------------------------------
module dda_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dda_pkg::ROW_W-1:0]         cfg_wdata,
  input  logic                              q_valid,
  input  dda_pkg::line_cmd_t                q_item,
  output logic                              q_pop,
  output logic                              div_start,
  output logic [dda_pkg::COORD_W-1:0]       div_dividend,
  output logic [dda_pkg::COORD_W-1:0]       div_divisor,
  input  logic                              div_done,
  input  logic [dda_pkg::QUO_W-1:0]         div_quotient,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_x [9:0], pixel_y [19:10], pixel_index [39:20]
  output logic [dda_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_COORD = 4'b0100,
    S_INDEX = 4'b1000
  } back_state_t;

  back_state_t                        state;
  logic                               active;
  logic                               major_is_x;
  logic [dda_pkg::COORD_W-1:0]        major_pos, major_limit, major_origin, minor_origin;
  logic                               slope_neg;
  logic signed [dda_pkg::SLOPE_W-1:0] slope;
  logic signed [dda_pkg::PROD_W-1:0]  prod;
  logic [dda_pkg::COORD_W-1:0]        pix_major;
  logic                               pix_last;
  logic [dda_pkg::COORD_W-1:0]        px, py;
  logic [dda_pkg::ROW_W-1:0]          row_width;
  logic [dda_pkg::COORD_W-1:0]        out_x, out_y;
  logic [dda_pkg::INDEX_W-1:0]        out_idx;
  logic                               out_last;

  logic                               is_step, step_last, out_free;
  logic signed [dda_pkg::OFFSET_W-1:0] offset;
  logic signed [dda_pkg::PROD_W-1:0]  prod_next;
  logic [dda_pkg::ACC_W-1:0]          acc;
  logic [dda_pkg::COORD_W-1:0]        minor;
  logic [dda_pkg::SLOPE_W-1:0]        slope_mag;
  logic [dda_pkg::IDX_FULL_W-1:0]     idx_sum;

  assign is_step   = q_item.cmd == dda_pkg::CMD_STEP;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = q_pop && !is_step && (q_item.major_mag != '0);
  assign div_dividend = q_item.minor_mag;
  assign div_divisor  = q_item.major_mag;

  assign step_last = major_pos >= major_limit;
  assign offset    = signed'({1'b0, major_pos}) - signed'({1'b0, major_origin});
  assign prod_next = offset * slope;

  // floor of the fixed-point sum keeps its low bits at the fraction boundary
  assign acc   = dda_pkg::ACC_W'({minor_origin, {dda_pkg::FRAC_BITS{1'b0}}})
               + {prod[dda_pkg::PROD_W-1], prod};
  assign minor = acc[dda_pkg::COORD_W+dda_pkg::FRAC_BITS-1:dda_pkg::FRAC_BITS];

  assign slope_mag = {1'b0, div_quotient};
  assign idx_sum   = dda_pkg::IDX_FULL_W'(py * row_width) + dda_pkg::IDX_FULL_W'(px);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  assign m_axis_tdata = {out_idx, out_y, out_x};
  assign m_axis_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active        <= 1'b0;
      row_width     <= dda_pkg::ROW_W'(dda_pkg::ROW_WIDTH_RESET);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_width <= cfg_wdata;
      end
      if (state == S_INDEX && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (!is_step) begin
              // a new start drops any line still in progress
              active       <= 1'b1;
              major_is_x   <= q_item.major_is_x;
              major_pos    <= q_item.major_lo;
              major_limit  <= q_item.major_hi;
              major_origin <= q_item.major_origin;
              minor_origin <= q_item.minor_origin;
              slope_neg    <= q_item.slope_neg;
              if (q_item.major_mag == '0) begin
                slope <= '0;
              end else begin
                state <= S_DIV;
              end
            end else if (active) begin
              prod      <= prod_next;
              pix_major <= major_pos;
              pix_last  <= step_last;
              if (step_last) begin
                active <= 1'b0;
              end else begin
                major_pos <= major_pos + 1'b1;
              end
              state <= S_COORD;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            slope <= slope_neg ? signed'(-slope_mag) : signed'(slope_mag);
            state <= S_IDLE;
          end
        end
        S_COORD: begin
          px    <= major_is_x ? pix_major : minor;
          py    <= major_is_x ? minor : pix_major;
          state <= S_INDEX;
        end
        S_INDEX: begin
          if (out_free) begin
            out_x         <= px;
            out_y         <= py;
            out_idx       <= idx_sum[dda_pkg::INDEX_W-1:0];
            out_last      <= pix_last;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_start_to_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV)
    else $error("divider started without entering the divide state");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (q_pop && is_step && active && step_last) |=> !active)
    else $error("line still active after its last pixel");

  a_index_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_INDEX && out_free) |=> (m_axis_tvalid && state == S_IDLE))
    else $error("pixel not loaded into the output register");

endmodule

// File: sv/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer: DDA line walker
// Commands arrive on the s_axis channel: tuser low is a start that loads two
// endpoints from tdata, tuser high is a step that yields one pixel of the
// current line on m_axis, with tlast on the line's final pixel. A start
// gives no item, and so does a step while no line is in progress.
// row_width (cfg_we / cfg_wdata) sets the pixel index pitch; write it idle.
// A two-entry command queue sits between intake and the walker, so inputs
// keep flowing while a pixel waits in the output register.
// Step: the walker finishes each pixel (multiply, add, index) before it takes
// the next command; the pixel then waits in the output register for m_axis.
// Start: with equal endpoints the command is taken and the slope set to zero;
// otherwise the walker waits on the serial divider (one slope bit a cycle).
// A stalled m_axis holds its item and the walker waits in the index stage;
// the queue then fills and s_axis_tready drops.
// Reset (rst, synchronous) empties the queue, ends any line, drops the
// output item and sets row_width to 640.
// ----------------------------------------------------------------------------
module dda_line_rasterizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dda_pkg::ROW_W-1:0]         cfg_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // x_start [9:0], y_start [19:10], x_end [29:20], y_end [39:30]
  input  logic [dda_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // command: 0 start, 1 step
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_x [9:0], pixel_y [19:10], pixel_index [39:20]
  output logic [dda_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);

  logic                            q_valid, q_pop;
  dda_pkg::line_cmd_t              q_item;
  logic                            div_start, div_done;
  logic [dda_pkg::COORD_W-1:0]     div_dividend, div_divisor;
  logic [dda_pkg::QUO_W-1:0]       div_quotient;

  dda_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  dda_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  dda_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .div_start     (div_start),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_done      (div_done),
    .div_quotient  (div_quotient),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: dv/dda_line_rasterizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb: self-checking testbench of the DDA line walker
// Drives start and step commands on s_axis and predicts every pixel from its
// own copy of the line state. Each pixel taken from m_axis is compared with
// the oldest predicted one. Runs directed corner lines, random line walks
// with noise, and two lines walked from their far endpoint, under changing
// back-pressure and several row_width settings.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;

  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 5000;

  typedef struct packed {
    logic [dda_pkg::COORD_W-1:0] x;
    logic [dda_pkg::COORD_W-1:0] y;
    logic [dda_pkg::INDEX_W-1:0] index;
    logic                        last;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [dda_pkg::ROW_W-1:0]      cfg_wdata = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [dda_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [dda_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  // predicted line state
  logic                               line_active;
  logic                               walk_major_x;
  logic [dda_pkg::COORD_W-1:0]        walk_pos;
  logic [dda_pkg::COORD_W-1:0]        walk_limit;
  logic [dda_pkg::COORD_W-1:0]        walk_origin;
  logic [dda_pkg::COORD_W-1:0]        cross_origin;
  logic signed [dda_pkg::SLOPE_W-1:0] slope_q16;
  logic [dda_pkg::ROW_W-1:0]          row_pitch;

  pixel_t expected_pixels[$];
  pixel_t want_pixel;
  pixel_t got_pixel;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int error_count   = 0;
  int items_sent    = 0;
  int pixels_seen   = 0;
  int pitch_writes  = 0;
  int stall_cycles  = 0;

  dda_line_rasterizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // pixel predictor, applied at the edge where a command is accepted
  function automatic void predict_command(dda_pkg::cmd_t c,
                                          logic [dda_pkg::IN_DATA_W-1:0] d);
    logic [dda_pkg::COORD_W-1:0] x1, y1, x2, y2, m1, m2, minor;
    longint dx, dy, adx, ady, major_d, minor_d, offset, acc;
    pixel_t p;
    if (c == dda_pkg::CMD_START) begin
      x1 = d[dda_pkg::COORD_W-1:0];
      y1 = d[2*dda_pkg::COORD_W-1 -: dda_pkg::COORD_W];
      x2 = d[3*dda_pkg::COORD_W-1 -: dda_pkg::COORD_W];
      y2 = d[4*dda_pkg::COORD_W-1 -: dda_pkg::COORD_W];
      dx = longint'(x2) - longint'(x1);
      dy = longint'(y2) - longint'(y1);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      walk_major_x = adx > ady;
      if (walk_major_x) begin
        m1 = x1; m2 = x2; major_d = dx; minor_d = dy; cross_origin = y1;
      end else begin
        m1 = y1; m2 = y2; major_d = dy; minor_d = dx; cross_origin = x1;
      end
      walk_origin = m1;
      walk_pos    = m1 < m2 ? m1 : m2;
      walk_limit  = m1 < m2 ? m2 : m1;
      if (major_d == 0) begin
        slope_q16 = '0;
      end else begin
        slope_q16 = dda_pkg::SLOPE_W'((minor_d * (longint'(1) << dda_pkg::FRAC_BITS))
                                      / major_d);
      end
      line_active = 1'b1;
    end else if (line_active) begin
      offset = longint'(walk_pos) - longint'(walk_origin);
      acc = longint'(cross_origin) * (longint'(1) << dda_pkg::FRAC_BITS)
            + offset * longint'(slope_q16);
      // arithmetic shift of a signed value is the floor
      minor = dda_pkg::COORD_W'(acc >>> dda_pkg::FRAC_BITS);
      p.x = walk_major_x ? walk_pos : minor;
      p.y = walk_major_x ? minor : walk_pos;
      p.index = dda_pkg::INDEX_W'(longint'(p.y) * longint'(row_pitch) + longint'(p.x));
      p.last = walk_pos >= walk_limit;
      expected_pixels = {expected_pixels, p};
      if (p.last) begin
        line_active = 1'b0;
      end else begin
        walk_pos = walk_pos + 1'b1;
      end
    end
  endfunction

  task automatic send_item(dda_pkg::cmd_t c, logic [dda_pkg::IN_DATA_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_command(c, d);
    items_sent++;
  endtask

  task automatic start_line(logic [dda_pkg::COORD_W-1:0] x1,
                            logic [dda_pkg::COORD_W-1:0] y1,
                            logic [dda_pkg::COORD_W-1:0] x2,
                            logic [dda_pkg::COORD_W-1:0] y2);
    send_item(dda_pkg::CMD_START, {y2, x2, y1, x1});
  endtask

  // steps carry random data, which the block ignores
  task automatic step_line(int n);
    repeat (n) send_item(dda_pkg::CMD_STEP, dda_pkg::IN_DATA_W'({$urandom, $urandom}));
  endtask

  task automatic drain_walker();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    // a trailing start or idle step gives no item but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_row_width(logic [dda_pkg::ROW_W-1:0] v);
    drain_walker();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    row_pitch = v;
    pitch_writes++;
  endtask

  task automatic test_directed();
    step_line(1);                      // step with no line in progress
    start_line(5, 5, 5, 5);            // equal endpoints, one pixel
    step_line(2);
    start_line(1023, 0, 0, 1023);      // tie goes to y, slope of minus one
    step_line(3);
    start_line(0, 1023, 1023, 1000);   // abandons the line above
    step_line(3);
    start_line(3, 7, 0, 6);            // walk starts at the far endpoint
    step_line(5);
    start_line(0, 0, 0, 1023);         // vertical, abandoned early
    step_line(1);
    start_line(1023, 1023, 1023, 1023);
    step_line(1);
  endtask

  task automatic test_random_lines(int n);
    int sent;
    int span;
    int steps;
    logic [dda_pkg::COORD_W-1:0] x1, y1, x2, y2;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 85) begin
        x1 = dda_pkg::COORD_W'($urandom);
        y1 = dda_pkg::COORD_W'($urandom);
        if ($urandom_range(9) == 0) begin
          x2 = dda_pkg::COORD_W'($urandom);
          y2 = dda_pkg::COORD_W'($urandom);
        end else begin
          x2 = x1 + dda_pkg::COORD_W'($urandom_range(24)) - dda_pkg::COORD_W'(12);
          y2 = y1 + dda_pkg::COORD_W'($urandom_range(24)) - dda_pkg::COORD_W'(12);
        end
        start_line(x1, y1, x2, y2);
        span = int'(walk_limit) - int'(walk_pos) + 1;
        if (span > 40 || $urandom_range(7) == 0) begin
          steps = $urandom_range(span < 40 ? span : 40);
        end else begin
          steps = span + $urandom_range(2);
        end
        step_line(steps);
        sent += 1 + steps;
      end else begin
        send_item(dda_pkg::cmd_t'($urandom_range(1)),
                  dda_pkg::IN_DATA_W'({$urandom, $urandom}));
        sent++;
      end
    end
  endtask

  // walks from the far endpoint begin at the largest offsets, both signs
  task automatic test_long_lines();
    start_line(1023, 0, 0, 700);
    step_line(dda_pkg::COORD_LIMIT / 16);
    start_line(1023, 1023, 0, 0);
    step_line(dda_pkg::COORD_LIMIT / 16);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_pixel.x     = m_axis_tdata[dda_pkg::COORD_W-1:0];
      got_pixel.y     = m_axis_tdata[2*dda_pkg::COORD_W-1 -: dda_pkg::COORD_W];
      got_pixel.index = m_axis_tdata[2*dda_pkg::COORD_W +: dda_pkg::INDEX_W];
      got_pixel.last  = m_axis_tlast;
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        error_count++;
        $display("%0t unexpected pixel: expected none, actual x=%0d y=%0d index=%0d last=%0b",
                 $time, got_pixel.x, got_pixel.y, got_pixel.index, got_pixel.last);
      end else begin
        want_pixel = expected_pixels.pop_front();
        if (got_pixel.x !== want_pixel.x) begin
          error_count++;
          $display("%0t pixel_x mismatch: expected %0d, actual %0d",
                   $time, want_pixel.x, got_pixel.x);
        end
        if (got_pixel.y !== want_pixel.y) begin
          error_count++;
          $display("%0t pixel_y mismatch: expected %0d, actual %0d",
                   $time, want_pixel.y, got_pixel.y);
        end
        if (got_pixel.index !== want_pixel.index) begin
          error_count++;
          $display("%0t pixel_index mismatch: expected %0d, actual %0d",
                   $time, want_pixel.index, got_pixel.index);
        end
        if (got_pixel.last !== want_pixel.last) begin
          error_count++;
          $display("%0t last mismatch: expected %0b, actual %0b",
                   $time, want_pixel.last, got_pixel.last);
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no item moved for %0d cycles, %0d pixels outstanding",
               $time, stall_cycles, expected_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    line_active  = 1'b0;
    walk_major_x = 1'b0;
    walk_pos     = '0;
    walk_limit   = '0;
    walk_origin  = '0;
    cross_origin = '0;
    slope_q16    = '0;
    row_pitch    = dda_pkg::ROW_W'(dda_pkg::ROW_WIDTH_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 17;
    sink_idle_pct = 87;
    test_directed();
    set_row_width(1);
    test_random_lines(110);

    src_idle_pct  = 87;
    sink_idle_pct = 17;
    set_row_width(1024);
    test_random_lines(110);
    set_row_width(0);
    test_long_lines();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_row_width(2047);
    test_random_lines(60);
    set_row_width(dda_pkg::ROW_W'($urandom_range(1024, 1)));
    test_random_lines(60);

    drain_walker();
    $display("covered %0d commands and %0d pixels over %0d row_width writes",
             items_sent, pixels_seen, pitch_writes);
    $display("lines: equal ends, ties, reversed walks, abandoned lines, far-end walks");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
